// ===== rtl/core/qdrp_pkg.sv =====
`default_nettype none
package qdrp_pkg;

  localparam int DEF_MAX_SEGMENTS = 63;
  localparam int DEF_COORD_BITS   = 32;
  localparam int DEPTH_BITS       = 32;
  localparam int SEG_BITS         = 6;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/qdrp_seq.sv =====
`default_nettype none
module qdrp_seq import qdrp_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int SW  = ((COORD_BITS > 33) ? COORD_BITS : 33) + 2,
  localparam int WW  = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1),
  localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS + 1) : 1,
  localparam int IDW = ((6 * COORD_BITS + DEPTH_BITS + SEG_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IDW-1:0]       in_tdata,
  output ctl_t                      o_ctl,
  output logic [WW-1:0]             o_wa,
  output logic [WW-1:0]             o_wb,
  output logic [WW-1:0]             o_wc,
  output logic [WW-1:0]             o_den,
  output logic signed [SW-1:0]      o_f [3],
  output logic signed [SW-1:0]      o_s [3],
  output logic signed [SW-1:0]      o_t [3]
);

  localparam int C = COORD_BITS;

  logic signed [SW-1:0] f_r [3];
  logic signed [SW-1:0] s_r [3];
  logic signed [SW-1:0] t_r [3];
  logic signed [SW-1:0] f_nxt [3];
  logic signed [SW-1:0] s_nxt [3];
  logic signed [SW-1:0] t_nxt [3];
  logic [IW-1:0]        n_r;
  logic [IW-1:0]        n_nxt;
  logic [IW-1:0]        cnt_r;
  logic [IW-1:0]        rest;
  logic                 busy_r;
  logic [SW-1:0]        depth_ext;
  logic [SEG_BITS-1:0]  seg;
  logic                 accept;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign seg       = in_tdata[6*C+DEPTH_BITS +: SEG_BITS];
  assign depth_ext = {{(SW-DEPTH_BITS){in_tdata[6*C+DEPTH_BITS-1]}},
                      in_tdata[6*C +: DEPTH_BITS]};
  assign rest      = n_r - cnt_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      f_nxt[c] = {{(SW-C){in_tdata[c*C+C-1]}}, in_tdata[c*C +: C]};
      t_nxt[c] = {{(SW-C){in_tdata[(3+c)*C+C-1]}}, in_tdata[(3+c)*C +: C]};
      s_nxt[c] = f_nxt[c] + t_nxt[c];
    end
    s_nxt[2] = s_nxt[2] + $signed({depth_ext[SW-3:0], 2'b00});
    if (seg == '0) begin
      n_nxt = IW'(1);
    end else if (seg > SEG_BITS'(MAX_SEGMENTS)) begin
      n_nxt = IW'(MAX_SEGMENTS);
    end else begin
      n_nxt = seg[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      o_ctl.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (en && busy_r) begin
        cnt_r <= cnt_r + IW'(1);
        if (cnt_r == n_r) begin
          busy_r <= 1'b0;
        end
      end
      if (en) begin
        o_ctl.valid <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_r <= f_nxt;
      s_r <= s_nxt;
      t_r <= t_nxt;
      n_r <= n_nxt;
    end
    if (en && busy_r) begin
      o_ctl.last <= (cnt_r == n_r);
      o_wa       <= WW'(rest) * WW'(rest);
      o_wb       <= WW'(cnt_r) * WW'(rest);
      o_wc       <= WW'(cnt_r) * WW'(cnt_r);
      o_den      <= WW'(n_r) * WW'(n_r);
      o_f        <= f_r;
      o_s        <= s_r;
      o_t        <= t_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= n_r) else $error("point index beyond segment count");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (en && busy_r && cnt_r == n_r && !accept) |=> !busy_r)
    else $error("route did not finish after its last point");
  a_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> n_r != '0) else $error("zero segments reached the sequencer");

endmodule
`default_nettype wire

// ===== rtl/core/qdrp_wsum.sv =====
`default_nettype none
module qdrp_wsum import qdrp_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int SW = ((COORD_BITS > 33) ? COORD_BITS : 33) + 2,
  localparam int WW = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1),
  localparam int PW = SW + WW + 1,
  localparam int NW = PW + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire ctl_t                 i_ctl,
  input  wire logic [WW-1:0]        i_wa,
  input  wire logic [WW-1:0]        i_wb,
  input  wire logic [WW-1:0]        i_wc,
  input  wire logic [WW-1:0]        i_den,
  input  wire logic signed [SW-1:0] i_f [3],
  input  wire logic signed [SW-1:0] i_s [3],
  input  wire logic signed [SW-1:0] i_t [3],
  output ctl_t                      o_ctl,
  output logic [WW-1:0]             o_den,
  output logic [NW-1:0]             o_mag [3],
  output logic                      o_neg [3]
);

  ctl_t                 m_ctl_r;
  ctl_t                 a_ctl_r;
  logic [WW-1:0]        m_den_r;
  logic [WW-1:0]        a_den_r;
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [PW-1:0] pc_r [3];
  logic signed [NW-1:0] num_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctl_r.valid <= 1'b0;
      a_ctl_r.valid <= 1'b0;
      o_ctl.valid   <= 1'b0;
    end else if (en) begin
      m_ctl_r.valid <= i_ctl.valid;
      a_ctl_r.valid <= m_ctl_r.valid;
      o_ctl.valid   <= a_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ctl_r.last <= i_ctl.last;
      a_ctl_r.last <= m_ctl_r.last;
      o_ctl.last   <= a_ctl_r.last;
      m_den_r      <= i_den;
      a_den_r      <= m_den_r;
      o_den        <= a_den_r;
      for (int c = 0; c < 3; c++) begin
        pa_r[c]  <= $signed({{(PW-WW){1'b0}}, i_wa}) * $signed({{(PW-SW){i_f[c][SW-1]}}, i_f[c]});
        pb_r[c]  <= $signed({{(PW-WW){1'b0}}, i_wb}) * $signed({{(PW-SW){i_s[c][SW-1]}}, i_s[c]});
        pc_r[c]  <= $signed({{(PW-WW){1'b0}}, i_wc}) * $signed({{(PW-SW){i_t[c][SW-1]}}, i_t[c]});
        num_r[c] <= NW'(pa_r[c]) + NW'(pb_r[c]) + NW'(pc_r[c]);
        o_neg[c] <= num_r[c][NW-1];
        o_mag[c] <= (num_r[c][NW-1] ? NW'(-num_r[c]) : NW'(num_r[c]))
                    + NW'(a_den_r >> 1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/qdrp_div.sv =====
`default_nettype none
module qdrp_div import qdrp_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int SW = ((COORD_BITS > 33) ? COORD_BITS : 33) + 2,
  localparam int WW = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1),
  localparam int NW = SW + WW + 3,
  localparam int QB = SW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire ctl_t          i_ctl,
  input  wire logic [WW-1:0] i_den,
  input  wire logic [NW-1:0] i_mag [3],
  input  wire logic          i_neg [3],
  output ctl_t               o_ctl,
  output logic [QB-1:0]      o_q [3],
  output logic               o_neg [3]
);

  ctl_t          ctl_r [QB];
  logic [WW-1:0] den_r [QB];
  logic [NW-1:0] rem_r [QB][3];
  logic [QB-1:0] q_r   [QB][3];
  logic          neg_r [QB][3];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    ctl_t          src_ctl;
    logic [WW-1:0] src_den;
    logic [NW-1:0] src_rem [3];
    logic [QB-1:0] src_q   [3];
    logic          src_neg [3];
    logic [NW-1:0] dsh;
    logic [NW:0]   trial [3];

    if (s == 0) begin : g_first
      assign src_ctl = i_ctl;
      assign src_den = i_den;
      assign src_rem = i_mag;
      assign src_q   = '{default: '0};
      assign src_neg = i_neg;
    end else begin : g_next
      assign src_ctl = ctl_r[s-1];
      assign src_den = den_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_q   = q_r[s-1];
      assign src_neg = neg_r[s-1];
    end

    assign dsh = NW'(src_den) << K;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = {1'b0, src_rem[c]} - {1'b0, dsh};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].valid <= 1'b0;
      end else if (en) begin
        ctl_r[s].valid <= src_ctl.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[s].last <= src_ctl.last;
        den_r[s]      <= src_den;
        for (int c = 0; c < 3; c++) begin
          neg_r[s][c] <= src_neg[c];
          q_r[s][c]   <= src_q[c] | (QB'(!trial[c][NW]) << K);
          rem_r[s][c] <= trial[c][NW] ? src_rem[c] : trial[c][NW-1:0];
        end
      end
    end
  end

  assign o_ctl = ctl_r[QB-1];
  assign o_q   = q_r[QB-1];
  assign o_neg = neg_r[QB-1];

endmodule
`default_nettype wire

// ===== rtl/core/quadratic_dip_route_points.sv =====
`default_nettype none
// Tessellates a dipping route into points of a quadratic Bezier curve whose control point
// is the midpoint of the two ends with twice the dip depth added to z. One word in gives
// segment_count+1 point words out (two for a count of zero), one point per clock while the
// output is taken; a route keeps the point sequencer busy until its last point, and the
// next route is taken once the last point has been issued. Each point then flows through
// a fully pipelined datapath of weight, multiply, sum and a restoring divider of one
// quotient bit per stage. Coordinates are exact, rounded to nearest with ties away from
// zero and saturated to the coordinate range.
module quadratic_dip_route_points import qdrp_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int IDW = ((6 * COORD_BITS + DEPTH_BITS + SEG_BITS + 7) / 8) * 8,
  localparam int ODW = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z, dip_depth, segment_count
  input  wire logic [IDW-1:0] in_tdata,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  // point_x, point_y, point_z
  output logic [ODW-1:0]      out_tdata,
  output logic                out_tlast
);

  localparam int C  = COORD_BITS;
  localparam int SW = ((COORD_BITS > 33) ? COORD_BITS : 33) + 2;
  localparam int WW = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1);
  localparam int NW = SW + WW + 3;
  localparam int QB = SW;

  logic                 en;
  ctl_t                 s_ctl;
  logic [WW-1:0]        s_wa;
  logic [WW-1:0]        s_wb;
  logic [WW-1:0]        s_wc;
  logic [WW-1:0]        s_den;
  logic signed [SW-1:0] s_f [3];
  logic signed [SW-1:0] s_s [3];
  logic signed [SW-1:0] s_t [3];
  ctl_t                 w_ctl;
  logic [WW-1:0]        w_den;
  logic [NW-1:0]        w_mag [3];
  logic                 w_neg [3];
  ctl_t                 d_ctl;
  logic [QB-1:0]        d_q [3];
  logic                 d_neg [3];
  logic [ODW-1:0]       data_nxt;
  logic [QB:0]          v [3];
  logic                 out_valid_r;
  logic                 out_last_r;
  logic [ODW-1:0]       out_data_r;

  assign en = !out_valid_r || out_tready;

  qdrp_seq #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_seq (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .o_ctl(s_ctl), .o_wa(s_wa), .o_wb(s_wb), .o_wc(s_wc), .o_den(s_den),
    .o_f(s_f), .o_s(s_s), .o_t(s_t)
  );

  qdrp_wsum #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_wsum (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_ctl(s_ctl), .i_wa(s_wa), .i_wb(s_wb), .i_wc(s_wc), .i_den(s_den),
    .i_f(s_f), .i_s(s_s), .i_t(s_t),
    .o_ctl(w_ctl), .o_den(w_den), .o_mag(w_mag), .o_neg(w_neg)
  );

  qdrp_div #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .i_ctl(w_ctl), .i_den(w_den), .i_mag(w_mag), .i_neg(w_neg),
    .o_ctl(d_ctl), .o_q(d_q), .o_neg(d_neg)
  );

  always_comb begin
    data_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      v[c] = d_neg[c] ? -{1'b0, d_q[c]} : {1'b0, d_q[c]};
      if ((v[c][QB:C-1] == '0) || (v[c][QB:C-1] == '1)) begin
        data_nxt[c*C +: C] = v[c][C-1:0];
      end else if (v[c][QB]) begin
        data_nxt[c*C +: C] = {1'b1, {(C-1){1'b0}}};
      end else begin
        data_nxt[c*C +: C] = {1'b0, {(C-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_last_r <= d_ctl.last;
      out_data_r <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== sim/quadratic_dip_route_points_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module quadratic_dip_route_points_tb;
  import qdrp_pkg::*;

  localparam int CB  = DEF_COORD_BITS;
  localparam int IDW = ((6 * CB + DEPTH_BITS + SEG_BITS + 7) / 8) * 8;
  localparam int ODW = ((3 * CB + 7) / 8) * 8;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 last;
  } route_point_t;

  class route_scoreboard;
    route_point_t pending[$];
    int errors;
    int points_seen;
    int routes_seen;

    function longint round_div(longint num, longint den);
      if (num < 0) return -((-num + den / 2) / den);
      return (num + den / 2) / den;
    endfunction

    function logic [CB-1:0] clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CB - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[CB-1:0];
    endfunction

    function void note_route(logic [IDW-1:0] w);
      longint fr[3], tt[3], sm[3], depth, n, den, wa, wb, wc;
      route_point_t p;
      routes_seen++;
      for (int c = 0; c < 3; c++) begin
        fr[c] = longint'($signed(w[c*CB +: CB]));
        tt[c] = longint'($signed(w[(3+c)*CB +: CB]));
        sm[c] = fr[c] + tt[c];
      end
      depth = longint'($signed(w[6*CB +: DEPTH_BITS]));
      sm[2] += depth * 4;
      n = w[6*CB+DEPTH_BITS +: SEG_BITS];
      if (n > DEF_MAX_SEGMENTS) n = DEF_MAX_SEGMENTS;
      if (n == 0) begin
        p = '{clamp_coord(fr[0]), clamp_coord(fr[1]), clamp_coord(fr[2]), 1'b0};
        pending = {pending, p};
        p = '{clamp_coord(tt[0]), clamp_coord(tt[1]), clamp_coord(tt[2]), 1'b1};
        pending = {pending, p};
        return;
      end
      den = n * n;
      for (longint i = 0; i <= n; i++) begin
        wa = (n - i) * (n - i);
        wb = i * (n - i);
        wc = i * i;
        p.x = clamp_coord(round_div(wa * fr[0] + wb * sm[0] + wc * tt[0], den));
        p.y = clamp_coord(round_div(wa * fr[1] + wb * sm[1] + wc * tt[1], den));
        p.z = clamp_coord(round_div(wa * fr[2] + wb * sm[2] + wc * tt[2], den));
        p.last = (i == n);
        pending = {pending, p};
      end
    endfunction

    function void check_point(logic [ODW-1:0] d, logic lst);
      route_point_t e;
      route_point_t a;
      points_seen++;
      a = '{d[0 +: CB], d[CB +: CB], d[2*CB +: CB], lst};
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%h y=%h z=%h last=%b", $time, a.x, a.y, a.z,
                 a.last);
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin
        errors++;
        $display("%0t: point_x expected %h actual %h", $time, e.x, a.x);
      end
      if (a.y !== e.y) begin
        errors++;
        $display("%0t: point_y expected %h actual %h", $time, e.y, a.y);
      end
      if (a.z !== e.z) begin
        errors++;
        $display("%0t: point_z expected %h actual %h", $time, e.z, a.z);
      end
      if (a.last !== e.last) begin
        errors++;
        $display("%0t: last_point expected %b actual %b", $time, e.last, a.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IDW-1:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic in_tready, out_tvalid, out_tlast;
  logic [ODW-1:0] out_tdata;
  longint cycles = 0;
  bit stall_on = 1'b0;
  route_scoreboard board = new();

  always #10 clk = ~clk;

  quadratic_dip_route_points uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("quadratic_dip_route_points_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_point(out_tdata, out_tlast);
    if (!stall_on) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0) && ((cycles % 37) < 30);
  end

  function logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 200000) - 100000;
      default: return $urandom();
    endcase
  endfunction

  function logic [IDW-1:0] make_route(logic [31:0] fx, fy, fz, tx, ty, tz, dd,
                                      logic [5:0] n);
    logic [IDW-1:0] w;
    w = '0;
    w[0 +: CB] = fx; w[CB +: CB] = fy; w[2*CB +: CB] = fz;
    w[3*CB +: CB] = tx; w[4*CB +: CB] = ty; w[5*CB +: CB] = tz;
    w[6*CB +: DEPTH_BITS] = dd;
    w[6*CB+DEPTH_BITS +: SEG_BITS] = n;
    return w;
  endfunction

  task automatic send_route(logic [IDW-1:0] w);
    in_tdata <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_route(w);
  endtask

  task automatic pause_sender(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [5:0] n;
    int burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_route(make_route(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, 32'h0000_8000, 0));
    send_route(make_route(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000,
                          0, 32'hffff_0000, 1));
    send_route(make_route(0, 0, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 2));
    send_route(make_route(0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000, 2));
    send_route(make_route(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 63));
    send_route(make_route(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 63));
    send_route(make_route(32'hffff_ffff, 1, 32'h0010_0000, 1, 32'hffff_ffff,
                          32'hfff0_0000, 32'h0000_0001, 3));
    send_route(make_route(32'h1234_5678, 32'h9abc_def0, 0, 32'h0fed_cba9, 32'h8765_4321,
                          0, 32'h0100_0000, 7));
    send_route(make_route(0, 0, 0, 0, 0, 0, 32'hffff_ffff, 32));
    drain();
    pause_sender(60);
    stall_on = 1'b1;

    for (int k = 0; k < 320; k += burst) begin
      burst = $urandom_range(1, 8);
      for (int j = 0; j < burst; j++) begin
        case ($urandom_range(0, 9))
          0: n = 6'd0;
          1: n = 6'd63;
          2: n = 6'($urandom_range(0, 63));
          default: n = 6'($urandom_range(1, 8));
        endcase
        send_route(make_route(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), n));
      end
      if (k > 150 && k < 160) drain();
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
    end
    drain();
    repeat (80) @(posedge clk);

    $display("Checked %0d points from %0d routes, covering zero, small and saturated",
             board.points_seen, board.routes_seen);
    $display("segment counts, extreme coordinates and dips, and stalls on both sides.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("quadratic_dip_route_points_tb OK");
    else
      $display("quadratic_dip_route_points_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
